/* rtl/core/chs_pkg.sv */
// Package with the sizes, codes, hash tables and address helpers of the chained key store.
`timescale 1ns / 1ps

package chs_pkg;

    localparam int BUCKETS     = 7;
    localparam int CHAIN_DEPTH = 8;
    localparam int SLOTS       = BUCKETS * CHAIN_DEPTH;

    localparam int KEY_W    = 31;
    localparam int HANDLE_W = 16;
    localparam int WORD_W   = KEY_W + HANDLE_W;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 6;

    localparam int CNT_W   = $clog2(CHAIN_DEPTH + 1);
    localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int TOTAL_W = $clog2(SLOTS + 1);

    localparam int KEY_BYTES  = (KEY_W + 7) / 8;
    localparam int BYTE_CNT_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    localparam int DIGIT_MOD = 10;
    localparam int SPREAD    = 10000;

    localparam logic [BKT_W-1:0] BUCKET_LUT [DIGIT_MOD] = '{
        BKT_W'((0 * SPREAD) % BUCKETS),
        BKT_W'((1 * SPREAD) % BUCKETS),
        BKT_W'((2 * SPREAD) % BUCKETS),
        BKT_W'((3 * SPREAD) % BUCKETS),
        BKT_W'((4 * SPREAD) % BUCKETS),
        BKT_W'((5 * SPREAD) % BUCKETS),
        BKT_W'((6 * SPREAD) % BUCKETS),
        BKT_W'((7 * SPREAD) % BUCKETS),
        BKT_W'((8 * SPREAD) % BUCKETS),
        BKT_W'((9 * SPREAD) % BUCKETS)
    };

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;

    typedef enum logic [1:0] {
        ST_DONE,
        ST_PRESENT,
        ST_NOT_FOUND,
        ST_FULL
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_SCAN,
        S_ACT,
        S_SHIFT,
        S_DONE
    } state_t;

    // Folds one more byte into a running remainder modulo ten.
    function automatic logic [3:0] mod10_step(input logic [3:0] r, input logic [7:0] b);
        logic [11:0] v;
        v = {r, b};
        for (int k = 7; k >= 0; k--) begin
            if (v >= (12'd10 << k)) begin
                v = v - (12'd10 << k);
            end
        end
        return v[3:0];
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [BKT_W-1:0] b,
                                                    input logic [CNT_W-1:0] i);
        return ADDR_W'(int'(b) * CHAIN_DEPTH + int'(i));
    endfunction

endpackage

/* rtl/core/chs_hash.sv */
// Bucket hash unit that reduces a key modulo ten one byte per cycle.
`timescale 1ns / 1ps

module chs_hash (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [chs_pkg::KEY_W-1:0] key,
    output logic                     done,
    output logic [chs_pkg::BKT_W-1:0] bucket
);
    import chs_pkg::*;

    logic                     run_reg, run_next;
    logic [BYTE_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [3:0]               rem_reg, rem_next;
    logic [8*KEY_BYTES-1:0]   shift_reg, shift_next;
    logic [BKT_W-1:0]         bucket_reg, bucket_next;
    logic [3:0]               rem_step;

    assign rem_step = mod10_step(rem_reg, shift_reg[8*KEY_BYTES-1 -: 8]);
    assign done     = run_reg && (cnt_reg == BYTE_CNT_W'(KEY_BYTES - 1));
    assign bucket   = bucket_reg;

    always_comb
    begin
        run_next    = run_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        shift_next  = shift_reg;
        bucket_next = bucket_reg;
        if (start)
        begin
            run_next   = 1'b1;
            cnt_next   = '0;
            rem_next   = '0;
            shift_next = (8*KEY_BYTES)'(key);
        end
        else if (run_reg)
        begin
            rem_next   = rem_step;
            shift_next = shift_reg << 8;
            cnt_next   = BYTE_CNT_W'(cnt_reg + 1'b1);
            if (done)
            begin
                run_next    = 1'b0;
                bucket_next = BUCKET_LUT[rem_step];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
            rem_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg  <= shift_next;
        bucket_reg <= bucket_next;
    end

endmodule

/* rtl/core/chained_hash_key_store.sv */
// Top level of the chained key store: control sequencer, slot memory and bucket fill counts.
// A request is hashed, the bucket's slots are compared in turn, the action is taken, each later
// entry is moved up on a delete, and the result is registered.
// One request at a time; the next can be taken in the same cycle as the result is presented.
// Reset clears all fill counts, the entry count and the handshakes; slot memory is not cleared.
`timescale 1ns / 1ps

module chained_hash_key_store (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  action,
    input  logic [chs_pkg::KEY_W-1:0]   key,
    input  logic [chs_pkg::HANDLE_W-1:0] record_handle,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  status,
    output logic [chs_pkg::POS_W-1:0]   chain_position,
    output logic [chs_pkg::HANDLE_W-1:0] found_handle,
    output logic [chs_pkg::COUNT_W-1:0] entry_count
);
    import chs_pkg::*;

    state_t                state_reg, state_next;
    logic [1:0]            action_reg, action_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [HANDLE_W-1:0]   handle_reg, handle_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                  pend_reg, pend_next;
    logic                  hit_reg, hit_next;
    logic [CNT_W-1:0]      hit_idx_reg, hit_idx_next;
    logic [HANDLE_W-1:0]   found_reg, found_next;
    logic [CNT_W-1:0]      dst_reg, dst_next;
    logic [CNT_W-1:0]      last_reg, last_next;
    status_t               res_status_reg, res_status_next;
    logic [POS_W-1:0]      res_pos_reg, res_pos_next;
    logic [HANDLE_W-1:0]   res_found_reg, res_found_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;
    logic [CNT_W-1:0]      fill_reg [BUCKETS];
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            out_status_reg, out_status_next;
    logic [POS_W-1:0]      out_pos_reg, out_pos_next;
    logic [HANDLE_W-1:0]   out_found_reg, out_found_next;
    logic [COUNT_W-1:0]    out_count_reg, out_count_next;

    logic [WORD_W-1:0]     slot_mem [SLOTS];
    logic [WORD_W-1:0]     rd_data_reg;
    logic                  mem_re, mem_we;
    logic [ADDR_W-1:0]     mem_raddr, mem_waddr;
    logic [WORD_W-1:0]     mem_wdata;

    logic                  fill_we;
    logic [CNT_W-1:0]      fill_wdata;
    logic [CNT_W-1:0]      fill_cur;
    logic                  hash_start, hash_done;
    logic [BKT_W-1:0]      bucket;
    logic                  match;

    chs_hash u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .key    (key),
        .done   (hash_done),
        .bucket (bucket)
    );

    assign in_ready       = (state_reg == S_IDLE);
    assign hash_start     = in_valid && in_ready;
    assign fill_cur       = fill_reg[bucket];
    assign match          = pend_reg && (rd_data_reg[WORD_W-1:HANDLE_W] == key_reg);
    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign chain_position = out_pos_reg;
    assign found_handle   = out_found_reg;
    assign entry_count    = out_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        key_next        = key_reg;
        handle_next     = handle_reg;
        idx_next        = idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        pend_next       = pend_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        found_next      = found_reg;
        dst_next        = dst_reg;
        last_next       = last_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_found_next  = res_found_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_found_next  = out_found_reg;
        out_count_next  = out_count_reg;
        mem_re          = 1'b0;
        mem_raddr       = slot_addr(bucket, idx_reg);
        mem_we          = 1'b0;
        mem_waddr       = slot_addr(bucket, dst_reg);
        mem_wdata       = rd_data_reg;
        fill_we         = 1'b0;
        fill_wdata      = fill_cur;

        case (state_reg)
            S_IDLE:
            begin
                pend_next = 1'b0;
                if (in_valid)
                begin
                    action_next = action;
                    key_next    = key;
                    handle_next = record_handle;
                    idx_next    = '0;
                    state_next  = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (match)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    found_next   = rd_data_reg[HANDLE_W-1:0];
                    pend_next    = 1'b0;
                    state_next   = S_ACT;
                end
                else if (idx_reg < fill_cur)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = slot_addr(bucket, idx_reg);
                    pend_next    = 1'b1;
                    cmp_idx_next = idx_reg;
                    idx_next     = CNT_W'(idx_reg + 1'b1);
                end
                else
                begin
                    hit_next   = 1'b0;
                    pend_next  = 1'b0;
                    state_next = S_ACT;
                end
            end
            S_ACT:
            begin
                res_found_next = '0;
                res_pos_next   = '0;
                state_next     = S_DONE;
                case (action_reg)
                    ACT_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            res_status_next = ST_PRESENT;
                            res_pos_next    = POS_W'(hit_idx_reg + 1'b1);
                        end
                        else if (int'(fill_cur) >= CHAIN_DEPTH)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            res_status_next = ST_DONE;
                            res_pos_next    = POS_W'(fill_cur + 1'b1);
                            mem_we          = 1'b1;
                            mem_waddr       = slot_addr(bucket, fill_cur);
                            mem_wdata       = {key_reg, handle_reg};
                            fill_we         = 1'b1;
                            fill_wdata      = CNT_W'(fill_cur + 1'b1);
                            total_next      = TOTAL_W'(total_reg + 1'b1);
                        end
                    end
                    ACT_DELETE:
                    begin
                        if (hit_reg)
                        begin
                            res_status_next = ST_DONE;
                            res_pos_next    = POS_W'(hit_idx_reg + 1'b1);
                            fill_we         = 1'b1;
                            fill_wdata      = CNT_W'(fill_cur - 1'b1);
                            total_next      = TOTAL_W'(total_reg - 1'b1);
                            if (CNT_W'(hit_idx_reg + 1'b1) < fill_cur)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = slot_addr(bucket, CNT_W'(hit_idx_reg + 1'b1));
                                dst_next   = hit_idx_reg;
                                last_next  = CNT_W'(fill_cur - 1'b1);
                                state_next = S_SHIFT;
                            end
                        end
                        else
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        if (hit_reg)
                        begin
                            res_status_next = ST_DONE;
                            res_pos_next    = POS_W'(hit_idx_reg + 1'b1);
                            res_found_next  = found_reg;
                        end
                        else
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                endcase
            end
            S_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = slot_addr(bucket, dst_reg);
                mem_wdata = rd_data_reg;
                if (CNT_W'(dst_reg + 1'b1) < last_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = slot_addr(bucket, CNT_W'(dst_reg + 2'd2));
                    dst_next  = CNT_W'(dst_reg + 1'b1);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_pos_next    = res_pos_reg;
                    out_found_next  = res_found_reg;
                    out_count_next  = COUNT_W'(total_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int b = 0; b < BUCKETS; b++)
            begin
                fill_reg[b] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (fill_we)
            begin
                fill_reg[bucket] <= fill_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        key_reg        <= key_next;
        handle_reg     <= handle_next;
        idx_reg        <= idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        found_reg      <= found_next;
        dst_reg        <= dst_next;
        last_reg       <= last_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_found_reg  <= res_found_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        out_found_reg  <= out_found_next;
        out_count_reg  <= out_count_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_mem[mem_raddr];
        end
    end

endmodule

/* rtl/core/chs_checker.sv */
// Port-level checker for the chained key store and the bind that attaches it.
`timescale 1ns / 1ps

module chs_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [1:0]                   status,
    input logic [chs_pkg::POS_W-1:0]    chain_position,
    input logic [chs_pkg::HANDLE_W-1:0] found_handle,
    input logic [chs_pkg::COUNT_W-1:0]  entry_count
);
    import chs_pkg::*;

    // Only one request is worked on at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(chain_position) && $stable(found_handle) && $stable(entry_count))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NOT_FOUND || status == ST_FULL)
            |-> chain_position == '0 && found_handle == '0)
        else $error("failed request reports a position or handle");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found_handle != '0 |-> status == ST_DONE && chain_position != '0)
        else $error("handle reported without a hit");

endmodule

bind chained_hash_key_store chs_checker u_chs_checker (.*);

/* sim/chained_hash_key_store_checker.sv */
// Checker that predicts every chained key store result and compares it with the block's output.
`timescale 1ns / 1ps

module chained_hash_key_store_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [1:0]                   action,
    input  logic [chs_pkg::KEY_W-1:0]    key,
    input  logic [chs_pkg::HANDLE_W-1:0] record_handle,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [1:0]                   status,
    input  logic [chs_pkg::POS_W-1:0]    chain_position,
    input  logic [chs_pkg::HANDLE_W-1:0] found_handle,
    input  logic [chs_pkg::COUNT_W-1:0]  entry_count,
    output int                           mismatches,
    output int                           pending_results
);
    import chs_pkg::*;

    typedef struct packed {
        status_t               status;
        logic [POS_W-1:0]      position;
        logic [HANDLE_W-1:0]   handle;
        logic [COUNT_W-1:0]    count;
    } store_result_t;

    store_result_t         awaited_results[$];
    logic [KEY_W-1:0]      stored_keys    [BUCKETS][CHAIN_DEPTH];
    logic [HANDLE_W-1:0]   stored_handles [BUCKETS][CHAIN_DEPTH];
    int                    chain_fill     [BUCKETS];
    int                    stored_total;
    int                    failures;
    int                    waiting;

    assign mismatches      = failures;
    assign pending_results = waiting;

    function automatic int bucket_for(input logic [KEY_W-1:0] k);
        return (int'(k % DIGIT_MOD) * SPREAD) % BUCKETS;
    endfunction

    function automatic store_result_t apply_request(input logic [1:0] act,
                                                    input logic [KEY_W-1:0] k,
                                                    input logic [HANDLE_W-1:0] h);
        store_result_t r;
        int b;
        int fill;
        int hit_at;
        b      = bucket_for(k);
        fill   = chain_fill[b];
        hit_at = fill;
        for (int i = fill - 1; i >= 0; i--)
        begin
            if (stored_keys[b][i] == k)
            begin
                hit_at = i;
            end
        end
        r.status   = ST_DONE;
        r.position = '0;
        r.handle   = '0;
        if (act == ACT_INSERT)
        begin
            if (hit_at < fill)
            begin
                r.status   = ST_PRESENT;
                r.position = POS_W'(hit_at + 1);
            end
            else if (fill >= CHAIN_DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                stored_keys[b][fill]    = k;
                stored_handles[b][fill] = h;
                chain_fill[b]           = fill + 1;
                stored_total++;
                r.position = POS_W'(fill + 1);
            end
        end
        else if (act == ACT_DELETE)
        begin
            if (hit_at < fill)
            begin
                for (int i = hit_at; i < fill - 1; i++)
                begin
                    stored_keys[b][i]    = stored_keys[b][i + 1];
                    stored_handles[b][i] = stored_handles[b][i + 1];
                end
                chain_fill[b] = fill - 1;
                stored_total--;
                r.position = POS_W'(hit_at + 1);
            end
            else
            begin
                r.status = ST_NOT_FOUND;
            end
        end
        else
        begin
            if (hit_at < fill)
            begin
                r.position = POS_W'(hit_at + 1);
                r.handle   = stored_handles[b][hit_at];
            end
            else
            begin
                r.status = ST_NOT_FOUND;
            end
        end
        r.count = COUNT_W'(stored_total);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        store_result_t exp;
        if (!rst_n)
        begin
            awaited_results.delete();
            for (int b = 0; b < BUCKETS; b++)
            begin
                chain_fill[b] = 0;
            end
            stored_total = 0;
            waiting      = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("Result with no request outstanding: status %0d position %0d",
                           status, chain_position);
                    failures++;
                end
                else
                begin
                    exp = awaited_results.pop_front();
                    if (status !== exp.status)
                    begin
                        $error("status: expected %0d, actual %0d", exp.status, status);
                        failures++;
                    end
                    if (chain_position !== exp.position)
                    begin
                        $error("chain_position: expected %0d, actual %0d",
                               exp.position, chain_position);
                        failures++;
                    end
                    if (found_handle !== exp.handle)
                    begin
                        $error("found_handle: expected %0d, actual %0d",
                               exp.handle, found_handle);
                        failures++;
                    end
                    if (entry_count !== exp.count)
                    begin
                        $error("entry_count: expected %0d, actual %0d",
                               exp.count, entry_count);
                        failures++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                awaited_results.push_back(apply_request(action, key, record_handle));
            end
            waiting = awaited_results.size();
        end
    end

endmodule

/* sim/chained_hash_key_store_test.sv */
// Testbench top for the chained key store: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps

module chained_hash_key_store_test;
    import chs_pkg::*;

    localparam logic [1:0] ACT_LOOKUP     = 2'd2;
    localparam logic [1:0] ACT_LOOKUP_ALT = 2'd3;
    localparam int         POOL_SIZE      = 64;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          action;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] record_handle;
    logic                out_valid;
    logic                out_ready;
    logic [1:0]          status;
    logic [POS_W-1:0]    chain_position;
    logic [HANDLE_W-1:0] found_handle;
    logic [COUNT_W-1:0]  entry_count;
    int                  mismatches;
    int                  pending_results;

    logic [KEY_W-1:0]    key_pool [POOL_SIZE];
    bit                  sender_calm;

    chained_hash_key_store dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .key            (key),
        .record_handle  (record_handle),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .chain_position (chain_position),
        .found_handle   (found_handle),
        .entry_count    (entry_count)
    );

    chained_hash_key_store_checker store_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .key             (key),
        .record_handle   (record_handle),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .chain_position  (chain_position),
        .found_handle    (found_handle),
        .entry_count     (entry_count),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int cycle_no;
        cycle_no  = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cycle_no++;
            if (cycle_no >= 3000 && cycle_no < 3400)
            begin
                out_ready <= 1'b0;
            end
            else if (cycle_no >= 9000 && cycle_no < 15000)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= 20);
            end
        end
    end

    task automatic send_request(input logic [1:0] act, input logic [KEY_W-1:0] k,
                                input logic [HANDLE_W-1:0] h);
        while (!sender_calm && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        key           <= k;
        record_handle <= h;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic directed_requests();
        send_request(ACT_LOOKUP, '0, 16'h1111);
        send_request(ACT_DELETE, '0, 16'h2222);
        send_request(ACT_INSERT, '0, 16'h0000);
        send_request(ACT_INSERT, '0, 16'h1234);
        send_request(ACT_INSERT, 31'd7, 16'h5555);
        send_request(ACT_INSERT, 31'h7FFF_FFFF, 16'hFFFF);
        send_request(ACT_LOOKUP_ALT, 31'h7FFF_FFFF, 16'h0000);
        send_request(ACT_DELETE, 31'd7, 16'hFFFF);
        send_request(ACT_LOOKUP, 31'h7FFF_FFFF, 16'h0000);
        for (int i = 1; i <= 6; i++)
        begin
            send_request(ACT_INSERT, KEY_W'(i * 10), HANDLE_W'(16'hA000 + i));
        end
        send_request(ACT_INSERT, 31'd70, 16'hBEEF);
        send_request(ACT_INSERT, '0, 16'hCAFE);
        send_request(ACT_LOOKUP, 31'd60, 16'h0000);
        send_request(ACT_DELETE, '0, 16'h0000);
        send_request(ACT_DELETE, 31'd60, 16'h0000);
        send_request(ACT_LOOKUP, '0, 16'h0000);
        send_request(ACT_INSERT, 31'd1, 16'hA5A5);
        send_request(ACT_DELETE, 31'h7FFF_FFFF, 16'h0000);
    endtask

    task automatic random_requests(input int count);
        int               pick;
        logic [1:0]       act;
        logic [KEY_W-1:0] k;
        for (int n = 0; n < count; n++)
        begin
            sender_calm = (n >= count / 3 && n < count / 3 + 200);
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                act = ACT_INSERT;
            end
            else if (pick < 70)
            begin
                act = ACT_DELETE;
            end
            else if (pick < 85)
            begin
                act = ACT_LOOKUP;
            end
            else
            begin
                act = ACT_LOOKUP_ALT;
            end
            if ($urandom_range(99) < 85)
            begin
                k = key_pool[$urandom_range(POOL_SIZE - 1)];
            end
            else
            begin
                k = KEY_W'($urandom());
            end
            send_request(act, k, HANDLE_W'($urandom()));
        end
        sender_calm = 1'b0;
    endtask

    // Overfills every bucket so the store reaches its full entry count, then looks up and deletes each key it sent.
    task automatic fill_and_drain();
        logic [KEY_W-1:0] fresh_keys [BUCKETS][CHAIN_DEPTH + 1];
        int               start;
        int               idx;
        for (int b = 0; b < BUCKETS; b++)
        begin
            for (int i = 0; i <= CHAIN_DEPTH; i++)
            begin
                fresh_keys[b][i] = KEY_W'($urandom_range(214748363) * 10 + b);
                send_request(ACT_INSERT, fresh_keys[b][i], HANDLE_W'($urandom()));
            end
        end
        for (int b = 0; b < BUCKETS; b++)
        begin
            start = $urandom_range(CHAIN_DEPTH);
            for (int i = 0; i <= CHAIN_DEPTH; i++)
            begin
                idx = (start + i) % (CHAIN_DEPTH + 1);
                send_request(ACT_LOOKUP, fresh_keys[b][idx], HANDLE_W'($urandom()));
                send_request(ACT_DELETE, fresh_keys[b][idx], HANDLE_W'($urandom()));
            end
        end
    endtask

    initial
    begin
        int settle;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        action        = ACT_INSERT;
        key           = '0;
        record_handle = '0;
        sender_calm   = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            key_pool[i] = KEY_W'($urandom());
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_requests();
        random_requests(500);
        fill_and_drain();
        random_requests(550);
        in_valid <= 1'b0;

        while (pending_results != 0)
        begin
            @(negedge clk);
        end
        for (settle = 0; settle < 4 + 2 * CHAIN_DEPTH + 10; settle++)
        begin
            @(negedge clk);
        end

        if (mismatches == 0 && pending_results == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
